FILE: rtl/ssd_pkg.sv
`timescale 1ns / 1ps
// shared constants and segment tables for the seven segment shift driver
// no dependencies; used by the front, queue, back and top level
package ssd_pkg;

   localparam int WORD_BITS   = 32;
   localparam int NUMBER_BITS = 16;
   localparam int CHAIN_BITS  = 32;
   localparam int CNT_BITS    = (CHAIN_BITS > 1) ? $clog2(CHAIN_BITS) : 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic FUNC_PATTERN = 1'b0;
   localparam logic FUNC_NUMBER  = 1'b1;

   // reciprocal multipliers for constant division, checked over the full input range
   localparam logic [16:0] RECIP_100   = 17'd83887;  // n / 100 = (n * 83887) >> 23
   localparam logic [15:0] RECIP_10    = 16'd52429;  // n / 10  = (n * 52429) >> 19
   localparam logic [7:0]  RECIP_10_Q1 = 8'd205;     // q / 10 for q < 1029, >> 11
   localparam logic [12:0] RECIP_10_Q2 = 13'd6554;   // q / 10 for q < 8192, >> 16

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [CNT_BITS-1:0]  cnt_type;

   // hundreds and units displays: PCDE--------GFAB
   function automatic logic [15:0] outer_seg(input logic [3:0] digit);
      logic [15:0] seg;
      case (digit)
         4'd0: seg = 16'h7007;
         4'd1: seg = 16'h4001;
         4'd2: seg = 16'h300B;
         4'd3: seg = 16'h600B;
         4'd4: seg = 16'h400D;
         4'd5: seg = 16'h600E;
         4'd6: seg = 16'h700E;
         4'd7: seg = 16'h4003;
         4'd8: seg = 16'h700F;
         4'd9: seg = 16'h600F;
         default: seg = 16'h0000;
      endcase
      return seg;
   endfunction

   // tens display: ----PCDEGFAB----
   function automatic logic [15:0] middle_seg(input logic [3:0] digit);
      logic [15:0] seg;
      case (digit)
         4'd0: seg = 16'h0770;
         4'd1: seg = 16'h0410;
         4'd2: seg = 16'h03B0;
         4'd3: seg = 16'h06B0;
         4'd4: seg = 16'h04D0;
         4'd5: seg = 16'h06E0;
         4'd6: seg = 16'h07E0;
         4'd7: seg = 16'h0430;
         4'd8: seg = 16'h07F0;
         4'd9: seg = 16'h06F0;
         default: seg = 16'h0000;
      endcase
      return seg;
   endfunction

endpackage

FILE: rtl/ssd_front.sv
`timescale 1ns / 1ps
// front end: accepts requests and builds the 32-bit segment word in three stages
// depends on ssd_pkg
module ssd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_func,
   input  logic [31:0]         req_pattern,
   input  logic [15:0]         req_number,
   output logic                word_valid,
   input  logic                word_ready,
   output ssd_pkg::word_type   word_data
);

   // stage 1: number / 100 and number / 10
   logic        s1_valid_ff, s1_valid_in;
   logic        s1_func_ff;
   logic [31:0] s1_pattern_ff;
   logic [15:0] s1_number_ff;
   logic [9:0]  s1_q100_ff;
   logic [12:0] s1_q10_ff;

   // stage 2: second division by ten and the units digit
   logic        s2_valid_ff, s2_valid_in;
   logic        s2_func_ff;
   logic [31:0] s2_pattern_ff;
   logic [9:0]  s2_q100_ff;
   logic [6:0]  s2_q100d_ff;
   logic [12:0] s2_q10_ff;
   logic [9:0]  s2_q10d_ff;
   logic [3:0]  s2_units_ff;

   // stage 3: finished word
   logic              s3_valid_ff, s3_valid_in;
   ssd_pkg::word_type s3_word_ff, s3_word_in;

   logic adv1, adv2, adv3;

   logic [32:0] prod100;
   logic [31:0] prod10;
   logic [17:0] prod100d;
   logic [25:0] prod10d;
   logic [15:0] tens_x10;
   logic [15:0] units_diff;
   logic [9:0]  hund_x10;
   logic [9:0]  hund_diff;
   logic [12:0] tens_d_x10;
   logic [12:0] tens_diff;
   logic [15:0] seg_hund, seg_tens, seg_units;

   assign adv3 = !s3_valid_ff || word_ready;
   assign adv2 = !s2_valid_ff || adv3;
   assign adv1 = !s1_valid_ff || adv2;

   assign req_ready  = adv1;
   assign word_valid = s3_valid_ff;
   assign word_data  = s3_word_ff;

   assign s1_valid_in = adv1 ? req_valid : s1_valid_ff;
   assign s2_valid_in = adv2 ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = adv3 ? s2_valid_ff : s3_valid_ff;

   assign prod100 = 33'(req_number) * 33'(ssd_pkg::RECIP_100);
   assign prod10  = 32'(req_number) * 32'(ssd_pkg::RECIP_10);

   assign prod100d   = 18'(s1_q100_ff) * 18'(ssd_pkg::RECIP_10_Q1);
   assign prod10d    = 26'(s1_q10_ff) * 26'(ssd_pkg::RECIP_10_Q2);
   assign tens_x10   = 16'({s1_q10_ff, 3'b000}) + 16'({s1_q10_ff, 1'b0});
   assign units_diff = s1_number_ff - tens_x10;

   assign hund_x10   = 10'({s2_q100d_ff, 3'b000}) + 10'({s2_q100d_ff, 1'b0});
   assign hund_diff  = s2_q100_ff - hund_x10;
   assign tens_d_x10 = 13'({s2_q10d_ff, 3'b000}) + 13'({s2_q10d_ff, 1'b0});
   assign tens_diff  = s2_q10_ff - tens_d_x10;

   assign seg_hund  = ssd_pkg::outer_seg(hund_diff[3:0]);
   assign seg_tens  = ssd_pkg::middle_seg(tens_diff[3:0]);
   assign seg_units = ssd_pkg::outer_seg(s2_units_ff);

   always_comb begin
      if (s2_func_ff == ssd_pkg::FUNC_NUMBER) begin
         s3_word_in = {seg_hund, seg_tens | seg_units};
      end else begin
         s3_word_in = s2_pattern_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_func_ff    <= req_func;
         s1_pattern_ff <= req_pattern;
         s1_number_ff  <= req_number;
         s1_q100_ff    <= prod100[32:23];
         s1_q10_ff     <= prod10[31:19];
      end
      if (adv2) begin
         s2_func_ff    <= s1_func_ff;
         s2_pattern_ff <= s1_pattern_ff;
         s2_q100_ff    <= s1_q100_ff;
         s2_q100d_ff   <= prod100d[17:11];
         s2_q10_ff     <= s1_q10_ff;
         s2_q10d_ff    <= prod10d[25:16];
         s2_units_ff   <= units_diff[3:0];
      end
      if (adv3) begin
         s3_word_ff <= s3_word_in;
      end
   end

endmodule

FILE: rtl/ssd_queue.sv
`timescale 1ns / 1ps
// short word queue between the front end and the serializer
// depends on ssd_pkg
module ssd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  ssd_pkg::word_type   in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output ssd_pkg::word_type   out_data
);

   ssd_pkg::word_type               mem_ff [ssd_pkg::QUEUE_DEPTH];
   logic [ssd_pkg::QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [ssd_pkg::QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [ssd_pkg::QCNT_BITS-1:0]   count_ff, count_in;
   logic                            push, pop;

   assign in_ready  = (count_ff != ssd_pkg::QCNT_BITS'(ssd_pkg::QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];

   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         if (wr_ptr_ff == ssd_pkg::QPTR_BITS'(ssd_pkg::QUEUE_DEPTH - 1)) begin
            wr_ptr_in = '0;
         end else begin
            wr_ptr_in = wr_ptr_ff + 1'b1;
         end
      end
      if (pop) begin
         if (rd_ptr_ff == ssd_pkg::QPTR_BITS'(ssd_pkg::QUEUE_DEPTH - 1)) begin
            rd_ptr_in = '0;
         end else begin
            rd_ptr_in = rd_ptr_ff + 1'b1;
         end
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ssd_pkg::QCNT_BITS'(ssd_pkg::QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not grow on push");

   a_head_held: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid && $stable(out_data))
      else $error("queue head changed while stalled");
`endif

endmodule

FILE: rtl/ssd_back.sv
`timescale 1ns / 1ps
// serializer: shifts each segment word out lsb first, flags the last chain bit
// depends on ssd_pkg
module ssd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                word_valid,
   output logic                word_ready,
   input  ssd_pkg::word_type   word_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_serial_bit,
   output logic                rsp_latch_now
);

   logic              busy_ff, busy_in;
   ssd_pkg::cnt_type  cnt_ff, cnt_in;
   ssd_pkg::word_type shift_ff, shift_in;
   logic              last, take, load;

   assign last = (cnt_ff == ssd_pkg::CNT_BITS'(ssd_pkg::CHAIN_BITS - 1));
   assign take = rsp_valid && rsp_ready;

   // a new word loads in the same cycle the latch bit leaves
   assign word_ready = !busy_ff || (take && last);
   assign load       = word_valid && word_ready;

   assign rsp_valid      = busy_ff;
   assign rsp_serial_bit = shift_ff[0];
   assign rsp_latch_now  = last;

   always_comb begin
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      if (load) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         shift_in = word_data;
      end else if (take) begin
         // zero fill covers chains longer than the word
         shift_in = {1'b0, shift_ff[ssd_pkg::WORD_BITS-1:1]};
         if (last) begin
            busy_in = 1'b0;
            cnt_in  = '0;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
   end

`ifndef SYNTH
   a_item_continues: assert property (@(posedge clock) disable iff (reset)
      take && !last |=> rsp_valid && cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("serial item cut short");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(cnt_ff) && $stable(shift_ff))
      else $error("serializer moved while stalled");

   a_load_restarts: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid && cnt_ff == '0)
      else $error("new word did not restart the bit count");

   a_idle_count: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> cnt_ff == '0)
      else $error("bit count nonzero while idle");
`endif

endmodule

FILE: rtl/seven_segment_shift_driver.sv
`timescale 1ns / 1ps
// the first serial bit of a request is valid once it has passed the front stages, the queue and the serializer
// the serializer shifts one bit per cycle while rsp_ready is high, CHAIN_BITS bits per request
// the three-stage digit front end and a two-word queue keep accepting while bits shift out
// reset: synchronous, clears valid flags, queue pointers and count and the bit counter; no clearing pass
// depends on ssd_pkg, ssd_front, ssd_queue, ssd_back
module seven_segment_shift_driver (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [31:0] req_pattern,
   input  logic [15:0] req_number,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_serial_bit,
   output logic        rsp_latch_now
);

   logic              f_valid, f_ready;
   ssd_pkg::word_type f_data;
   logic              q_valid, q_ready;
   ssd_pkg::word_type q_data;

   ssd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_func    (req_func),
      .req_pattern (req_pattern),
      .req_number  (req_number),
      .word_valid  (f_valid),
      .word_ready  (f_ready),
      .word_data   (f_data)
   );

   ssd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   (f_data),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_data)
   );

   ssd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .word_valid     (q_valid),
      .word_ready     (q_ready),
      .word_data      (q_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_serial_bit (rsp_serial_bit),
      .rsp_latch_now  (rsp_latch_now)
   );

endmodule
